/* hw/rtl/angle_sample_debouncer_top_assert.svh */
// assertion macros for the angle sample debouncer
`ifndef ANGLE_SAMPLE_DEBOUNCER_TOP_ASSERT_SVH
`define ANGLE_SAMPLE_DEBOUNCER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ASD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/asd_pkg.sv */
// shared constants and types for the angle sample debouncer
package asd_pkg;

    localparam int unsigned RAW_W   = 12;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned TOL_W   = 8;
    localparam int unsigned DEB_W   = 16;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 16;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
    localparam logic [RAW_W-1:0]   RAW_FULL    = 12'd4095;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ENABLED   = 2'd0;
    localparam logic [IDX_W-1:0] REG_TOLERANCE = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 2'd2;

    // register reset values
    localparam logic             ENABLED_RESET  = 1'b0;
    localparam logic [TOL_W-1:0] TOLERANCE_RESET = 8'd3;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd100;

    // configuration bundle handed to the tracker
    typedef struct packed {
        logic             enabled;
        logic [TOL_W-1:0] tolerance;
        logic [DEB_W-1:0] debounce_time;
    } asd_cfg_t;

endpackage

/* hw/rtl/asd_scale.sv */
// scales a 12-bit converter reading to 0..180 degrees, floor(raw*180/4095)
module asd_scale (
    input  logic [asd_pkg::RAW_W-1:0]   raw_sample,
    output logic [asd_pkg::ANGLE_W-1:0] angle
);
    import asd_pkg::*;

    localparam int unsigned PROD_W = RAW_W + ANGLE_W;

    logic [PROD_W-1:0]  prod;
    logic [ANGLE_W-1:0] quot_lo;
    logic [RAW_W:0]     rem;

    // product fits in 20 bits
    assign prod = PROD_W'(raw_sample) * PROD_W'(ANGLE_MAX);

    // x/4096 is at most one below x/4095; remainder is low bits plus quotient
    assign quot_lo = prod[PROD_W-1:RAW_W];
    assign rem     = {1'b0, prod[RAW_W-1:0]} + (RAW_W+1)'(quot_lo);

    // one correction step
    assign angle = (rem >= {1'b0, RAW_FULL}) ? quot_lo + 8'd1 : quot_lo;

endmodule

/* hw/rtl/asd_track.sv */
// debounce state and decision for one scaled reading per transfer
module asd_track (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [asd_pkg::ANGLE_W-1:0]  angle,
    input  logic [asd_pkg::TIME_W-1:0]   now_ms,
    input  asd_pkg::asd_cfg_t            cfg,
    output logic [asd_pkg::ANGLE_W-1:0]  angle_result
);
    import asd_pkg::*;

    logic [ANGLE_W-1:0] reported_reg, reported_next;
    logic               cand_valid_reg, cand_valid_next;
    logic [ANGLE_W-1:0] cand_angle_reg, cand_angle_next;
    logic [TIME_W-1:0]  cand_start_reg, cand_start_next;

    logic [ANGLE_W-1:0] diff_rep;
    logic [ANGLE_W-1:0] diff_cand;
    logic [TIME_W-1:0]  elapsed;
    logic               far_rep;
    logic               near_cand;
    logic               settled;

    // distances and elapsed time with wrap
    assign diff_rep  = (angle > reported_reg) ? angle - reported_reg : reported_reg - angle;
    assign diff_cand = (angle > cand_angle_reg) ? angle - cand_angle_reg
                                                : cand_angle_reg - angle;
    assign far_rep   = diff_rep > cfg.tolerance;
    assign near_cand = cand_valid_reg && (diff_cand <= cfg.tolerance);
    assign elapsed   = now_ms - cand_start_reg;
    assign settled   = elapsed >= TIME_W'(cfg.debounce_time);

    // next state
    always_comb
    begin
        reported_next   = reported_reg;
        cand_valid_next = cand_valid_reg;
        cand_angle_next = cand_angle_reg;
        cand_start_next = cand_start_reg;
        if (step && cfg.enabled)
        begin
            if (far_rep)
            begin
                if (near_cand)
                begin
                    if (settled)
                    begin
                        reported_next   = angle;
                        cand_valid_next = 1'b0;
                    end
                end
                else
                begin
                    cand_valid_next = 1'b1;
                    cand_angle_next = angle;
                    cand_start_next = now_ms;
                end
            end
            else
            begin
                cand_valid_next = 1'b0;
            end
        end
    end

    // result value for the transfer leaving this cycle
    assign angle_result = cfg.enabled ? reported_next : '0;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg   <= ANGLE_RESET;
            cand_valid_reg <= 1'b0;
            cand_angle_reg <= '0;
            cand_start_reg <= '0;
        end
        else
        begin
            reported_reg   <= reported_next;
            cand_valid_reg <= cand_valid_next;
            cand_angle_reg <= cand_angle_next;
            cand_start_reg <= cand_start_next;
        end
    end

endmodule

/* hw/rtl/angle_sample_debouncer_top.sv */
// a result passes the input register and then the result register before it is offered
// throughput: one item per cycle while the result side accepts, the debounce state updates in a single pass per item
// a waiting result stalls the input side once the input register also holds an item
// reset: asynchronous active low; reported angle 90, no candidate, enabled 0,
// tolerance 3, debounce time 100 ms
module angle_sample_debouncer_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,   // raw_sample[11:0], now_ms[43:12], zero pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // angle_out[7:0]
    input  logic                       cfg_we,
    input  logic [asd_pkg::IDX_W-1:0]  cfg_index,
    input  logic [asd_pkg::CFG_W-1:0]  cfg_wdata
);
    import asd_pkg::*;

    `include "angle_sample_debouncer_top_assert.svh"

    asd_cfg_t           cfg_reg;
    logic               s1_valid_reg;
    logic [ANGLE_W-1:0] s1_angle_reg;
    logic [TIME_W-1:0]  s1_now_reg;
    logic               out_valid_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic [ANGLE_W-1:0] in_angle;
    logic [ANGLE_W-1:0] angle_result;
    logic               advance;
    logic               in_xfer;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled       <= ENABLED_RESET;
            cfg_reg.tolerance     <= TOLERANCE_RESET;
            cfg_reg.debounce_time <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLED:   cfg_reg.enabled       <= cfg_wdata[0];
                REG_TOLERANCE: cfg_reg.tolerance     <= cfg_wdata[TOL_W-1:0];
                REG_DEBOUNCE:  cfg_reg.debounce_time <= cfg_wdata[DEB_W-1:0];
                default:       ;
            endcase
        end
    end

    // input-side scaling
    asd_scale u_scale (
        .raw_sample (s_tdata[RAW_W-1:0]),
        .angle      (in_angle)
    );

    // pipeline flow control
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_angle_reg <= in_angle;
            s1_now_reg   <= s_tdata[RAW_W +: TIME_W];
        end
    end

    // debounce tracker
    asd_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .angle        (s1_angle_reg),
        .now_ms       (s1_now_reg),
        .cfg          (cfg_reg),
        .angle_result (angle_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_angle_reg <= angle_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_angle_reg;

    // checks
    `ASD_ASSERT_NOW(a_angle_range, m_tvalid, m_tdata <= ANGLE_MAX, "angle out of range")
    `ASD_ASSERT_NEXT(a_disabled_zero, advance && !cfg_reg.enabled, m_tdata == '0,
        "disabled result not zero")
    `ASD_ASSERT_NOW(a_stall_full, !s_tready, m_tvalid && s1_valid_reg,
        "input stalled with free stage")
    `ASD_ASSERT_NEXT(a_capture, in_xfer, s1_valid_reg, "accepted transfer not captured")

endmodule

/* sim/tb.sv */
// testbench for the angle sample debouncer: directed, back-pressure and random checks
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asd_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    // index with no register behind it
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [47:0]        s_tdata;   // raw_sample[11:0], now_ms[43:12], zero pad
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;   // angle_out[7:0]
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;

    // mirror of the block's registers and debounce state
    logic               cfg_enabled;
    logic [TOL_W-1:0]   cfg_tol;
    logic [DEB_W-1:0]   cfg_deb;
    logic [7:0]         held_angle;
    logic               cand_valid;
    logic [7:0]         cand_angle;
    logic [31:0]        cand_start;

    // expected angles, oldest first
    logic [7:0]         angle_q[$];
    logic [7:0]         want_angle;

    // traffic shaping
    logic               src_idle_on;
    logic               sink_idle_on;
    logic               hold_go = 1'b0;
    logic               hold_on = 1'b0;
    int                 sink_stall = 0;

    // bookkeeping
    int                 err_count = 0;
    int                 samples_sent = 0;
    int                 results_checked = 0;
    int                 accept_count = 0;
    int                 wrap_count = 0;
    int                 stall_cycles = 0;
    int                 cycle_count = 0;

    angle_sample_debouncer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cycle limit and input stall count
    always @(posedge clk)
    begin
        cycle_count++;
        if (s_tvalid && !s_tready)
            stall_cycles++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, angle_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // exact floor(raw * 180 / 4095)
    function automatic logic [7:0] to_angle(input logic [11:0] raw);
        int unsigned prod;
        prod = raw;
        prod = prod * ANGLE_MAX / RAW_FULL;
        return prod[7:0];
    endfunction

    function automatic logic [7:0] angle_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // advance the mirrored state by one sample and queue the expected angle
    task automatic predict_angle(input logic [11:0] raw, input logic [31:0] now);
        logic [7:0]  ang;
        logic [31:0] elapsed;
        if (!cfg_enabled)
        begin
            angle_q.push_back(8'd0);
            return;
        end
        ang = to_angle(raw);
        if (angle_gap(ang, held_angle) > cfg_tol)
        begin
            if (cand_valid && angle_gap(ang, cand_angle) <= cfg_tol)
            begin
                // elapsed time wraps modulo 2^32
                elapsed = now - cand_start;
                if (now < cand_start)
                    wrap_count++;
                if (elapsed >= {16'd0, cfg_deb})
                begin
                    held_angle = ang;
                    cand_valid = 1'b0;
                    accept_count++;
                end
            end
            else
            begin
                cand_valid = 1'b1;
                cand_angle = ang;
                cand_start = now;
            end
        end
        else
            cand_valid = 1'b0;
        angle_q.push_back(held_angle);
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // offer one sample; returns right after the transfer
    task automatic send_sample(input logic [11:0] raw, input logic [31:0] now);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, now, raw};
        do
            @(posedge clk);
        while (!s_tready);
        predict_angle(raw, now);
        samples_sent++;
    endtask

    // stop offering and wait until every expected angle has come back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only once the block has drained
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ENABLED:   cfg_enabled = val[0];
            REG_TOLERANCE: cfg_tol     = val[TOL_W-1:0];
            REG_DEBOUNCE:  cfg_deb     = val[DEB_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // receiving and checking
    // ------------------------------------------------------------------

    // result side ready, with random stall bursts and the long hold
    always @(negedge clk)
    begin
        if (hold_on)
            m_tready <= 1'b0;
        else if (sink_stall != 0)
        begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else if (sink_idle_on && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            sink_stall <= $urandom_range(0, 9);
        end
        else
            m_tready <= 1'b1;
    end

    // long receiver hold, started once by the back-pressure test
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (angle_q.size() == 0)
                report_mismatch($sformatf("angle %0d arrived with nothing pending", m_tdata));
            else
            begin
                want_angle = angle_q.pop_front();
                results_checked++;
                if (m_tdata !== want_angle)
                    report_mismatch($sformatf("angle_out got %0d, want %0d",
                                              m_tdata, want_angle));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: disabled output, then tolerance 3 and 100 ms debounce
    task automatic test_reset_values();
        send_sample(12'd0, 32'd0);
        send_sample(12'd4095, 32'd1);
        send_sample(12'd2048, 32'd2);
        write_reg(REG_ENABLED, 16'd1);
        send_sample(12'd2048, 32'd3);
        send_sample(12'd2184, 32'd3);
        send_sample(12'd2184, 32'd102);
        send_sample(12'd2184, 32'd103);
    endtask

    // field extremes and each special case of the debounce rule
    task automatic test_directed();
        // candidate restart, then a reading near it before the debounce time, across the timestamp wrap
        send_sample(12'd0,    32'hFFFF_FFC0);
        send_sample(12'd4095, 32'hFFFF_FFF0);
        send_sample(12'd4094, 32'h0000_0030);
        // acceptance across the wrap: accepted angle is the current reading, not the stored candidate
        send_sample(12'd4050, 32'h0000_0054);
        // disabled: output zero, state untouched across enable writes
        write_reg(REG_ENABLED, 16'd0);
        send_sample(12'd1, 32'h0000_0100);
        write_reg(REG_ENABLED, 16'd1);
        send_sample(12'd4050, 32'h0000_0101);
        // a reading back within tolerance drops the candidate
        send_sample(12'd2048, 32'd1000);
        send_sample(12'd4050, 32'd1001);
        send_sample(12'd2048, 32'd2000);
        send_sample(12'd2048, 32'd2099);
        send_sample(12'd2048, 32'd2100);
        // tolerance above full scale
        write_reg(REG_TOLERANCE, 16'd255);
        send_sample(12'd4095, 32'd3000);
        write_reg(REG_TOLERANCE, 16'd181);
        send_sample(12'd0, 32'd3001);
        // zero tolerance and zero debounce
        write_reg(REG_TOLERANCE, 16'd0);
        write_reg(REG_DEBOUNCE, 16'd0);
        send_sample(12'd2071, 32'd5);
        send_sample(12'd2071, 32'd5);
        // write to an unused index must leave all registers alone
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(12'd2048, 32'd6);
        send_sample(12'd2048, 32'd6);
        // longest debounce
        write_reg(REG_TOLERANCE, 16'd3);
        write_reg(REG_DEBOUNCE, 16'hFFFF);
        send_sample(12'd4095, 32'd0);
        send_sample(12'd4095, 32'd65534);
        send_sample(12'd4095, 32'hFFFF_FFFF);
    endtask

    // steady readings with jitter and glitches around random targets
    task automatic run_episodes(input int count, input logic [31:0] ts0);
        logic [31:0] ts;
        int          target;
        int          left;
        int          span;
        int          raw_i;
        int          step_max;
        ts       = ts0;
        left     = 0;
        target   = 0;
        step_max = int'(cfg_deb) / 6 + 3;
        span     = (cfg_tol > 8 ? 8 : int'(cfg_tol)) * 11;
        for (int n = 0; n < count; n++)
        begin
            if (left == 0)
            begin
                target = $urandom_range(0, 4095);
                left   = $urandom_range(4, 30);
            end
            left--;
            if ($urandom_range(0, 9) < 2)
                // noise: any reading at any time
                send_sample(12'($urandom_range(0, 4095)), $urandom);
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    raw_i = $urandom_range(0, 4095);
                else
                    raw_i = target - span + int'($urandom_range(0, 2 * span));
                if (raw_i < 0)
                    raw_i = 0;
                if (raw_i > 4095)
                    raw_i = 4095;
                ts += $urandom_range(0, step_max);
                send_sample(raw_i[11:0], ts);
            end
        end
    endtask

    // receiver holds off long enough that the input side stalls
    task automatic test_backpressure();
        write_reg(REG_TOLERANCE, 16'd2);
        write_reg(REG_DEBOUNCE, 16'd20);
        src_idle_on = 1'b0;
        hold_go     = 1'b1;
        run_episodes(60, $urandom);
        src_idle_on = 1'b1;
    endtask

    // many register settings with well-formed and noisy sample streams
    task automatic test_random_phases();
        logic [CFG_W-1:0] tol;
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] en;
        logic [31:0]      ts0;
        for (int p = 0; p < 13; p++)
        begin
            en  = 16'd1;
            ts0 = $urandom;
            case (p)
                0: begin tol = 16'd3;   deb = 16'd100; end
                1: begin tol = 16'd0;   deb = 16'd0; end
                2: begin tol = 16'd180; deb = 16'hFFFF; ts0 = 32'hFFF0_0000; end
                3: begin tol = 16'd255; deb = 16'd10; end
                4: begin tol = 16'd8;   deb = 16'd0;  en = 16'd0; end
                5: begin tol = 16'd1;   deb = 16'd50; ts0 = 32'hFFFF_FF00; end
                default:
                begin
                    tol = 16'($urandom_range(0, 20));
                    deb = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 400));
                end
            endcase
            // last part runs without idling on either side
            if (p >= 11)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            write_reg(REG_TOLERANCE, tol);
            write_reg(REG_DEBOUNCE, deb);
            write_reg(REG_ENABLED, en);
            run_episodes(145, ts0);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        cfg_enabled  = ENABLED_RESET;
        cfg_tol      = TOLERANCE_RESET;
        cfg_deb      = DEBOUNCE_RESET;
        held_angle   = ANGLE_RESET;
        cand_valid   = 1'b0;
        cand_angle   = 8'd0;
        cand_start   = 32'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_directed();
        test_backpressure();
        test_random_phases();

        settle();
        repeat (10) @(posedge clk);
        $display("run covered %0d samples and %0d checked angles over 13 register settings",
                 samples_sent, results_checked);
        $display("debounce acceptances %0d, wrapped elapsed times %0d, input stall cycles %0d",
                 accept_count, wrap_count, stall_cycles);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
